// File: hdl/class_queues_urgent_front_insert_macros.svh
// Assertion macros used by the port-level checker of the class queue block.
// No dependencies; include by bare file name.
`ifndef CLASS_QUEUES_URGENT_FRONT_INSERT_MACROS_SVH
`define CLASS_QUEUES_URGENT_FRONT_INSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CQUFI_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cqufi check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CQUFI_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cqufi check failed");

`endif

// File: hdl/cqufi_pkg.sv
// Shared constants, codes and types for the class queue block.
// No dependencies; used by scoped names in the design, checker and bench files.
package cqufi_pkg;

	localparam int NUM_CLASSES_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int ID_WIDTH_DEF    = 16;

	localparam int CLASS_W   = 5;
	localparam int STATUS_W  = 2;
	localparam int QCOUNT_W  = 4;
	// wide enough for an occupancy of up to 127
	localparam int CNT_MAX_W = 7;

	localparam logic [STATUS_W-1:0] ST_ADDED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SERVED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_SERVE = 1'b1;

	localparam logic [1:0] OP_KEEP = 2'd0;
	localparam logic [1:0] OP_HEAD = 2'd1;
	localparam logic [1:0] OP_TAIL = 2'd2;
	localparam logic [1:0] OP_POP  = 2'd3;

	typedef struct packed {
		logic                 we;
		logic [1:0]           op;
		logic [CNT_MAX_W-1:0] cnt;
	} cell_ctrl_t;

endpackage

// File: hdl/cqufi_cell.sv
// One slot position of every class queue: a per-class slot memory plus shift logic.
// Depends on cqufi_pkg; neighbors are chained in the top level.
module cqufi_cell #(
	parameter int NUM_CLASSES = cqufi_pkg::NUM_CLASSES_DEF,
	parameter int ENT_W       = cqufi_pkg::ID_WIDTH_DEF + 1,
	parameter int INDEX       = 0,
	parameter int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1
) (
	input  logic                   clk,
	input  logic                   rd_en,
	input  logic [CLS_W-1:0]       addr,
	input  cqufi_pkg::cell_ctrl_t  ctrl,
	input  logic [ENT_W-1:0]       new_ent,
	input  logic [ENT_W-1:0]       prev_ent,
	input  logic [ENT_W-1:0]       next_ent,
	output logic [ENT_W-1:0]       cur_ent
);

	localparam logic [cqufi_pkg::CNT_MAX_W-1:0] IDX  = cqufi_pkg::CNT_MAX_W'(INDEX);
	localparam logic [cqufi_pkg::CNT_MAX_W-1:0] IDX1 = cqufi_pkg::CNT_MAX_W'(INDEX + 1);

	logic [ENT_W-1:0] mem_q [NUM_CLASSES];
	logic [ENT_W-1:0] rd_q;
	logic [ENT_W-1:0] nxt;

	always_comb begin
		case (ctrl.op)
			cqufi_pkg::OP_HEAD: nxt = (IDX <= ctrl.cnt) ? prev_ent : rd_q;
			cqufi_pkg::OP_TAIL: nxt = (IDX == ctrl.cnt) ? new_ent : rd_q;
			cqufi_pkg::OP_POP: begin
				// the slot vacated at the tail is freed
				if (IDX1 < ctrl.cnt)
					nxt = next_ent;
				else if (IDX1 == ctrl.cnt)
					nxt = '0;
				else
					nxt = rd_q;
			end
			default: nxt = rd_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.we && ctrl.op != cqufi_pkg::OP_KEEP)
			mem_q[addr] <= nxt;
		if (rd_en)
			rd_q <= mem_q[addr];
	end

	assign cur_ent = rd_q;

endmodule

// File: hdl/class_queues_urgent_front_insert.sv
// Top level of the bank of bounded per-class queues with urgent head insertion.
// Depends on cqufi_pkg and cqufi_cell (one cell per slot position).
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: action; tdata: class_index, entry_id, is_urgent
//  m_*      out  m_tvalid/m_tready  tuser: status; tdata: served_id, served_urgent, queue_count
//
// A transaction reads the slot row of the addressed class from the cell memories, then
// shifts it one place through the cell chain (urgent add, serve) or fills the tail slot
// (regular add) and writes it back, held by m_tready stalls until the output is free.
// Reset clears the state machine, output valid and per-class count valid bits;
// slot memories need no clearing pass.
module class_queues_urgent_front_insert #(
	parameter int NUM_CLASSES = cqufi_pkg::NUM_CLASSES_DEF,
	parameter int QUEUE_DEPTH = cqufi_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = cqufi_pkg::ID_WIDTH_DEF,
	parameter int IN_W  = ((cqufi_pkg::CLASS_W + ID_WIDTH + 1 + 7) / 8) * 8,
	parameter int OUT_W = ((ID_WIDTH + 1 + cqufi_pkg::QCOUNT_W + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [4:0] class_index, [ID_WIDTH+4:5] entry_id, [ID_WIDTH+5] is_urgent
	input  logic [IN_W-1:0]                 s_tdata,
	// [0] action
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [ID_WIDTH-1:0] served_id, [ID_WIDTH] served_urgent, [ID_WIDTH+4:ID_WIDTH+1] queue_count
	output logic [OUT_W-1:0]                m_tdata,
	// [1:0] status
	output logic [cqufi_pkg::STATUS_W-1:0]  m_tuser
);

	localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ENT_W = ID_WIDTH + 1;
	localparam int CW    = cqufi_pkg::CLASS_W;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;

	// input fields
	logic [CW-1:0]       in_class;
	logic [ID_WIDTH-1:0] in_id;
	logic                in_urg;
	logic                accept;

	logic                action_s1;
	logic                cls_ok_s1;
	logic [ID_WIDTH-1:0] id_s1;
	logic                urg_s1;
	logic [CLS_W-1:0]    addr_s1;
	logic [CNT_W-1:0]    cnt_rd_s1;
	logic                cnt_vld_s1;

	logic [CNT_W-1:0]    cnt_mem_q [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] cnt_vld_q;

	logic [CLS_W-1:0]    addr;
	logic [CNT_W-1:0]    cnt_cur;
	logic [CNT_W-1:0]    cnt_new;
	logic [cqufi_pkg::STATUS_W-1:0] status;
	logic [1:0]          op;
	logic                out_free;
	logic                commit;
	cqufi_pkg::cell_ctrl_t ctrl;

	logic [ENT_W-1:0]    ent_rd [QUEUE_DEPTH];
	logic [ENT_W-1:0]    new_ent;

	logic                           m_tvalid_q;
	logic [cqufi_pkg::STATUS_W-1:0] status_q;
	logic [ID_WIDTH-1:0]            sid_q;
	logic                           surg_q;
	logic [cqufi_pkg::QCOUNT_W-1:0] qcnt_q;

	assign in_class = s_tdata[CW-1:0];
	assign in_id    = s_tdata[CW+ID_WIDTH-1:CW];
	assign in_urg   = s_tdata[CW+ID_WIDTH];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign commit   = (state_q == S_EXEC) && out_free;
	assign addr     = (state_q == S_IDLE) ? CLS_W'(in_class) : addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (accept) state_q <= S_EXEC;
				S_EXEC: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= s_tuser;
			cls_ok_s1  <= (32'(in_class) < NUM_CLASSES);
			id_s1      <= in_id;
			urg_s1     <= in_urg;
			addr_s1    <= CLS_W'(in_class);
			cnt_rd_s1  <= cnt_mem_q[CLS_W'(in_class)];
			cnt_vld_s1 <= cnt_vld_q[CLS_W'(in_class)];
		end
	end

	assign cnt_cur = cnt_vld_s1 ? cnt_rd_s1 : '0;

	always_comb begin
		op      = cqufi_pkg::OP_KEEP;
		cnt_new = cnt_cur;
		if (!cls_ok_s1) begin
			status  = (action_s1 == cqufi_pkg::ACT_SERVE) ? cqufi_pkg::ST_EMPTY
				: cqufi_pkg::ST_FULL;
			cnt_new = '0;
		end else if (action_s1 == cqufi_pkg::ACT_ADD) begin
			if (cnt_cur == CNT_W'(QUEUE_DEPTH)) begin
				status = cqufi_pkg::ST_FULL;
			end else begin
				status  = cqufi_pkg::ST_ADDED;
				op      = urg_s1 ? cqufi_pkg::OP_HEAD : cqufi_pkg::OP_TAIL;
				cnt_new = cnt_cur + 1'b1;
			end
		end else begin
			if (cnt_cur == '0) begin
				status = cqufi_pkg::ST_EMPTY;
			end else begin
				status  = cqufi_pkg::ST_SERVED;
				op      = cqufi_pkg::OP_POP;
				cnt_new = cnt_cur - 1'b1;
			end
		end
	end

	assign ctrl.we  = commit;
	assign ctrl.op  = op;
	assign ctrl.cnt = cqufi_pkg::CNT_MAX_W'(cnt_cur);
	assign new_ent  = {urg_s1, id_s1};

	// per-class occupancy; a class never written reads as empty
	always_ff @(posedge clk) begin
		if (commit && cls_ok_s1)
			cnt_mem_q[addr_s1] <= cnt_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_vld_q <= '0;
		else if (commit && cls_ok_s1)
			cnt_vld_q[addr_s1] <= 1'b1;
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [ENT_W-1:0] prev_ent;
		logic [ENT_W-1:0] next_ent;

		if (i == 0) begin : g_head
			assign prev_ent = new_ent;
		end else begin : g_mid
			assign prev_ent = ent_rd[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_ent = '0;
		end else begin : g_body
			assign next_ent = ent_rd[i+1];
		end

		cqufi_cell #(
			.NUM_CLASSES(NUM_CLASSES),
			.ENT_W      (ENT_W),
			.INDEX      (i),
			.CLS_W      (CLS_W)
		) u_cell (
			.clk     (clk),
			.rd_en   (accept),
			.addr    (addr),
			.ctrl    (ctrl),
			.new_ent (new_ent),
			.prev_ent(prev_ent),
			.next_ent(next_ent),
			.cur_ent (ent_rd[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (commit)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status;
			qcnt_q   <= cqufi_pkg::QCOUNT_W'(cnt_new);
			if (status == cqufi_pkg::ST_SERVED) begin
				sid_q  <= ent_rd[0][ID_WIDTH-1:0];
				surg_q <= ent_rd[0][ID_WIDTH];
			end else begin
				sid_q  <= '0;
				surg_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = OUT_W'({qcnt_q, surg_q, sid_q});

endmodule

// File: hdl/cqufi_chk.sv
// Port-level checker for the class queue block, bound to the top level.
// Depends on cqufi_pkg and the macro header.
`include "class_queues_urgent_front_insert_macros.svh"

module cqufi_chk #(
	parameter int ID_WIDTH    = cqufi_pkg::ID_WIDTH_DEF,
	parameter int QUEUE_DEPTH = cqufi_pkg::QUEUE_DEPTH_DEF,
	parameter int OUT_W       = ((ID_WIDTH + 1 + cqufi_pkg::QCOUNT_W + 7) / 8) * 8
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [OUT_W-1:0]               m_tdata,
	input logic [cqufi_pkg::STATUS_W-1:0] m_tuser
);

	localparam int QC_LO = ID_WIDTH + 1;
	localparam int QC_HI = ID_WIDTH + cqufi_pkg::QCOUNT_W;

	logic [ID_WIDTH:0]                 served;
	logic [cqufi_pkg::QCOUNT_W-1:0]    qcnt;

	assign served = m_tdata[ID_WIDTH:0];
	assign qcnt   = m_tdata[QC_HI:QC_LO];

	`CQUFI_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// one transaction in flight at a time
	`CQUFI_ASSERT_NXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)

	`CQUFI_ASSERT_IMP(a_served_zero, clk, arst_n,
		m_tvalid && m_tuser != cqufi_pkg::ST_SERVED, served == '0)

	`CQUFI_ASSERT_IMP(a_empty_count, clk, arst_n,
		m_tvalid && m_tuser == cqufi_pkg::ST_EMPTY, qcnt == '0)

	`CQUFI_ASSERT_IMP(a_added_count, clk, arst_n,
		m_tvalid && m_tuser == cqufi_pkg::ST_ADDED, (QUEUE_DEPTH >= 16) || qcnt != '0)

endmodule

bind class_queues_urgent_front_insert cqufi_chk #(
	.ID_WIDTH   (ID_WIDTH),
	.QUEUE_DEPTH(QUEUE_DEPTH),
	.OUT_W      (OUT_W)
) u_cqufi_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

// File: bench/testbench.sv
// Self-checking bench for the bank of per-class queues with urgent head insertion.
// Needs cqufi_pkg and class_queues_urgent_front_insert; a scoreboard class predicts
// each response from accepted requests, a plain task drives the request side and an initial block the response side.
`timescale 1ns / 1ps

localparam int TB_CLASSES = cqufi_pkg::NUM_CLASSES_DEF;
localparam int TB_DEPTH   = cqufi_pkg::QUEUE_DEPTH_DEF;
localparam int TB_ID_W    = cqufi_pkg::ID_WIDTH_DEF;

typedef struct packed {
	logic                          action;
	logic [cqufi_pkg::CLASS_W-1:0] cls;
	logic [TB_ID_W-1:0]            id;
	logic                          urgent;
} request_t;

typedef struct packed {
	logic [cqufi_pkg::STATUS_W-1:0] status;
	logic [TB_ID_W-1:0]             served_id;
	logic                           served_urgent;
	logic [cqufi_pkg::QCOUNT_W-1:0] count;
} response_t;

// Mirrors the queue contents and holds the responses still owed by the block.
class queue_book;
	logic [TB_ID_W-1:0] slot_id  [TB_CLASSES][TB_DEPTH];
	bit                 slot_urg [TB_CLASSES][TB_DEPTH];
	int                 occupancy[TB_CLASSES];
	response_t          pending[$];
	int                 errors;
	int                 tally[4];

	function new();
		errors = 0;
		foreach (occupancy[c]) occupancy[c] = 0;
		foreach (tally[s]) tally[s] = 0;
	endfunction

	function void note_request(request_t r);
		response_t want;
		int c;
		int n;
		want = '0;
		c = r.cls;
		n = occupancy[c];
		if (r.action == cqufi_pkg::ACT_ADD) begin
			if (n >= TB_DEPTH) begin
				want.status = cqufi_pkg::ST_FULL;
			end else begin
				if (r.urgent) begin
					for (int i = n; i > 0; i--) begin
						slot_id[c][i]  = slot_id[c][i-1];
						slot_urg[c][i] = slot_urg[c][i-1];
					end
					slot_id[c][0]  = r.id;
					slot_urg[c][0] = 1'b1;
				end else begin
					slot_id[c][n]  = r.id;
					slot_urg[c][n] = 1'b0;
				end
				n++;
				want.status = cqufi_pkg::ST_ADDED;
			end
		end else if (n == 0) begin
			want.status = cqufi_pkg::ST_EMPTY;
		end else begin
			want.served_id     = slot_id[c][0];
			want.served_urgent = slot_urg[c][0];
			for (int i = 1; i < n; i++) begin
				slot_id[c][i-1]  = slot_id[c][i];
				slot_urg[c][i-1] = slot_urg[c][i];
			end
			n--;
			want.status = cqufi_pkg::ST_SERVED;
		end
		occupancy[c] = n;
		want.count = n[cqufi_pkg::QCOUNT_W-1:0];
		tally[want.status]++;
		pending.push_back(want);
	endfunction

	function void check_response(response_t got);
		response_t want;
		if (pending.size() == 0) begin
			$error("unexpected transaction: status %0d id %h", got.status, got.served_id);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			errors++;
		end
		if (got.served_id !== want.served_id) begin
			$error("served_id: expected %h, got %h", want.served_id, got.served_id);
			errors++;
		end
		if (got.served_urgent !== want.served_urgent) begin
			$error("served_urgent: expected %0d, got %0d", want.served_urgent,
				got.served_urgent);
			errors++;
		end
		if (got.count !== want.count) begin
			$error("queue_count: expected %0d, got %0d", want.count, got.count);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam int IN_W  = ((cqufi_pkg::CLASS_W + TB_ID_W + 1 + 7) / 8) * 8;
	localparam int OUT_W = ((TB_ID_W + 1 + cqufi_pkg::QCOUNT_W + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 1225;
	localparam int QUIET_ITEMS  = 150;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [IN_W-1:0]                s_tdata;
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [OUT_W-1:0]               m_tdata;
	logic [cqufi_pkg::STATUS_W-1:0] m_tuser;

	queue_book book;
	bit        idle_on;
	int        stall_left;

	class_queues_urgent_front_insert u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

	// receiver side: random stall bursts while idling is enabled
	initial begin
		m_tready   = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (!idle_on) begin
				stall_left = 0;
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 7);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			book.check_response('{status: m_tuser, served_id: m_tdata[TB_ID_W-1:0],
				served_urgent: m_tdata[TB_ID_W],
				count: m_tdata[TB_ID_W+cqufi_pkg::QCOUNT_W:TB_ID_W+1]});
	end

	function automatic request_t mk(logic action, int cls, int id, logic urgent);
		request_t r;
		r.action = action;
		r.cls    = cls[cqufi_pkg::CLASS_W-1:0];
		r.id     = id[TB_ID_W-1:0];
		r.urgent = urgent;
		return r;
	endfunction

	// one transaction on the request side, with an optional idle burst in front
	task automatic send_item(request_t r);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 8);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.action;
		s_tdata  <= {{(IN_W - cqufi_pkg::CLASS_W - TB_ID_W - 1){1'b0}},
			r.urgent, r.id, r.cls};
		do @(posedge clk); while (!s_tready);
		book.note_request(r);
	endtask

	initial begin
		request_t directed[$];
		request_t r;
		int       sent;
		int       hot_a;
		int       hot_b;
		int       add_pct;
		int       len;
		int       pick;

		book     = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		idle_on  = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// top class: empty serve, fill to full mixing urgent and regular, two rejects,
		// drain to empty and one more serve
		directed.push_back(mk(cqufi_pkg::ACT_SERVE, 31, 0, 1'b0));
		directed.push_back(mk(cqufi_pkg::ACT_ADD, 31, 16'hFFFF, 1'b1));
		directed.push_back(mk(cqufi_pkg::ACT_ADD, 31, 16'h0000, 1'b0));
		directed.push_back(mk(cqufi_pkg::ACT_ADD, 31, 16'h1234, 1'b1));
		directed.push_back(mk(cqufi_pkg::ACT_ADD, 31, 16'hABCD, 1'b0));
		directed.push_back(mk(cqufi_pkg::ACT_ADD, 31, 16'h0001, 1'b0));
		directed.push_back(mk(cqufi_pkg::ACT_ADD, 31, 16'h8000, 1'b1));
		directed.push_back(mk(cqufi_pkg::ACT_ADD, 31, 16'h7FFF, 1'b0));
		directed.push_back(mk(cqufi_pkg::ACT_ADD, 31, 16'h5555, 1'b1));
		directed.push_back(mk(cqufi_pkg::ACT_ADD, 31, 16'hAAAA, 1'b0));
		directed.push_back(mk(cqufi_pkg::ACT_ADD, 31, 16'h0F0F, 1'b1));
		for (int i = 0; i < TB_DEPTH + 1; i++)
			directed.push_back(mk(cqufi_pkg::ACT_SERVE, 31, 16'hFFFF, 1'b1));
		// class zero: a single entry of each kind goes in and out, freed slot reused
		directed.push_back(mk(cqufi_pkg::ACT_ADD, 0, 16'h0001, 1'b1));
		directed.push_back(mk(cqufi_pkg::ACT_SERVE, 0, 0, 1'b0));
		directed.push_back(mk(cqufi_pkg::ACT_SERVE, 0, 0, 1'b0));
		directed.push_back(mk(cqufi_pkg::ACT_ADD, 0, 16'hFFFF, 1'b0));
		directed.push_back(mk(cqufi_pkg::ACT_SERVE, 0, 0, 1'b0));
		foreach (directed[i])
			send_item(directed[i]);

		// episodes on two hot classes with a fill, drain or balanced bias
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			hot_a = $urandom_range(0, TB_CLASSES - 1);
			hot_b = $urandom_range(0, TB_CLASSES - 1);
			case ($urandom_range(0, 2))
				0: add_pct = 75;
				1: add_pct = 25;
				default: add_pct = 50;
			endcase
			len     = $urandom_range(20, 60);
			idle_on = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
				if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
					idle_on = 1'b0;
				pick = $urandom_range(0, 9);
				r = mk(($urandom_range(0, 99) < add_pct) ? cqufi_pkg::ACT_ADD
						: cqufi_pkg::ACT_SERVE,
					(pick == 0) ? $urandom_range(0, TB_CLASSES - 1)
						: (pick < 6) ? hot_a : hot_b,
					$urandom, $urandom_range(0, 1));
				send_item(r);
				sent++;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (book.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d directed and %0d random requests over %0d classes",
			directed.size(), RANDOM_ITEMS, TB_CLASSES);
		$display("responses: %0d added, %0d full, %0d served, %0d empty",
			book.tally[cqufi_pkg::ST_ADDED], book.tally[cqufi_pkg::ST_FULL],
			book.tally[cqufi_pkg::ST_SERVED], book.tally[cqufi_pkg::ST_EMPTY]);
		if (book.errors == 0 && book.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
